### rtl/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg: shared types and constants for the 2-D convolution engine
// Field widths, configuration register layout, opcodes, controller states and
// the command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package c2d_pkg;

	// default sizes of the stores
	localparam int unsigned MAP_DEPTH_DEF        = 2048;
	localparam int unsigned WEIGHT_DEPTH_DEF     = 256;
	localparam int unsigned MAX_OUT_CHANNELS_DEF = 4;

	// item field widths
	localparam int OP_W   = 2;
	localparam int ADDR_W = 11;
	localparam int DATA_W = 16;
	localparam int OCH_W  = 2;
	localparam int POS_W  = 5;

	// configuration register widths
	localparam int DIM_W      = 6;
	localparam int ICH_W      = 2;
	localparam int KER_W      = 3;
	localparam int OCNT_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;

	// arithmetic
	localparam int ACC_W      = 40;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int FRAC_SHIFT = 8;

	// reach of the map and weight walk pointers for any register contents
	localparam int MPTR_W = 14;
	localparam int WPTR_W = 11;

	typedef enum logic [OP_W-1:0] {
		OP_MAP     = 2'd0,
		OP_WEIGHT  = 2'd1,
		OP_BIAS    = 2'd2,
		OP_COMPUTE = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_ROWS      = 3'd0,
		REG_IN_COLS      = 3'd1,
		REG_IN_CHANNELS  = 3'd2,
		REG_KERNEL_ROWS  = 3'd3,
		REG_KERNEL_COLS  = 3'd4,
		REG_OUT_CHANNELS = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0]  in_rows;
		logic [DIM_W-1:0]  in_cols;
		logic [ICH_W-1:0]  in_channels;
		logic [KER_W-1:0]  kernel_rows;
		logic [KER_W-1:0]  kernel_cols;
		logic [OCNT_W-1:0] out_channels;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		in_rows:      DIM_W'(28),
		in_cols:      DIM_W'(28),
		in_channels:  ICH_W'(1),
		kernel_rows:  KER_W'(3),
		kernel_cols:  KER_W'(3),
		out_channels: OCNT_W'(2)
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP1,
		ST_SETUP2,
		ST_SETUP3,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;      // input transfer this cycle
		logic setup1;    // form map offset and loop products
		logic setup2;    // load walk pointers, preload bias
		logic setup3;    // form weight base address
		logic issue;     // read one map word and weight, advance walk
		logic load_out;  // move result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad;       // requested position outside the output
		logic empty;     // no multiply-accumulate steps
		logic last;      // current step is the final one
		logic busy;      // multiply pipeline still holds steps
	} sts_t;

endpackage

### rtl/c2d_ram.sv
// ----------------------------------------------------------------------------
// c2d_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module c2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/c2d_ctrl.sv
// ----------------------------------------------------------------------------
// c2d_ctrl: sequencer for the convolution engine
// Takes input transfers, steps the datapath through setup, the
// multiply-accumulate walk and drain, and owns the output valid flag.
// ----------------------------------------------------------------------------
module c2d_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [c2d_pkg::OP_W-1:0] op,
	output logic                     out_valid,
	input  logic                     out_ready,
	input  c2d_pkg::sts_t            sts,
	output c2d_pkg::cmd_t            cmd
);

	c2d_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || out_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c2d_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			c2d_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && c2d_pkg::op_t'(op) == c2d_pkg::OP_COMPUTE) begin
					state_d = c2d_pkg::ST_SETUP1;
				end
			end
			c2d_pkg::ST_SETUP1: begin
				cmd.setup1 = 1'b1;
				state_d    = sts.bad ? c2d_pkg::ST_DONE : c2d_pkg::ST_SETUP2;
			end
			c2d_pkg::ST_SETUP2: begin
				cmd.setup2 = 1'b1;
				state_d    = c2d_pkg::ST_SETUP3;
			end
			c2d_pkg::ST_SETUP3: begin
				cmd.setup3 = 1'b1;
				state_d    = sts.empty ? c2d_pkg::ST_DRAIN : c2d_pkg::ST_RUN;
			end
			c2d_pkg::ST_RUN: begin
				cmd.issue = 1'b1;
				if (sts.last) begin
					state_d = c2d_pkg::ST_DRAIN;
				end
			end
			c2d_pkg::ST_DRAIN: begin
				if (!sts.busy) begin
					state_d = c2d_pkg::ST_DONE;
				end
			end
			c2d_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = c2d_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = c2d_pkg::ST_IDLE;
			end
		endcase
	end

	// output valid: set on load, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_walk_stops_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && sts.last) |=> !cmd.issue)
		else $error("walk issued a step past the last one");

	a_compute_starts_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && c2d_pkg::op_t'(op) == c2d_pkg::OP_COMPUTE)
		|=> (state_q == c2d_pkg::ST_SETUP1))
		else $error("compute transfer did not start setup");

	a_load_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (out_valid_q && state_q == c2d_pkg::ST_IDLE))
		else $error("loaded result not presented");
`endif

endmodule

### rtl/c2d_dp.sv
// ----------------------------------------------------------------------------
// c2d_dp: datapath of the convolution engine
// Configuration registers, map/weight RAMs, bias registers, the address walk
// over channels and kernel positions, the multiply-accumulate pipeline and
// the output register with shift and saturation.
// ----------------------------------------------------------------------------
module c2d_dp #(
	parameter int unsigned MAP_DEPTH        = c2d_pkg::MAP_DEPTH_DEF,
	parameter int unsigned WEIGHT_DEPTH     = c2d_pkg::WEIGHT_DEPTH_DEF,
	parameter int unsigned MAX_OUT_CHANNELS = c2d_pkg::MAX_OUT_CHANNELS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [c2d_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [c2d_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic [c2d_pkg::OP_W-1:0]              op,
	input  logic [c2d_pkg::ADDR_W-1:0]            address,
	input  logic signed [c2d_pkg::DATA_W-1:0]     value,
	input  logic [c2d_pkg::OCH_W-1:0]             out_channel,
	input  logic [c2d_pkg::POS_W-1:0]             out_row,
	input  logic [c2d_pkg::POS_W-1:0]             out_col,
	input  c2d_pkg::cmd_t                         cmd,
	output c2d_pkg::sts_t                         sts,
	output logic signed [c2d_pkg::DATA_W-1:0]     conv_value,
	output logic                                  saturated,
	output logic                                  bad_position
);

	localparam int M_AW  = $clog2(MAP_DEPTH);
	localparam int W_AW  = $clog2(WEIGHT_DEPTH);
	localparam int MP_W  = (M_AW > c2d_pkg::MPTR_W) ? M_AW : c2d_pkg::MPTR_W;
	localparam int WP_W  = (W_AW + 1 > c2d_pkg::WPTR_W) ? W_AW + 1 : c2d_pkg::WPTR_W;
	localparam int BI_W  = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
	localparam int OX_W  = (BI_W > c2d_pkg::OCH_W) ? BI_W : c2d_pkg::OCH_W;
	localparam int OC_W  = OX_W + 1;
	localparam int CK_W  = c2d_pkg::ICH_W + c2d_pkg::KER_W;
	localparam int CKK_W = c2d_pkg::ICH_W + 2 * c2d_pkg::KER_W;
	localparam int RC_W  = 2 * c2d_pkg::DIM_W;
	localparam int Q_W   = c2d_pkg::ACC_W - c2d_pkg::FRAC_SHIFT;
	localparam int DW    = c2d_pkg::DATA_W;

	c2d_pkg::cfg_t cfg_q;
	c2d_pkg::op_t  op_e;

	// captured compute request
	logic [c2d_pkg::OCH_W-1:0] och_q;
	logic [c2d_pkg::POS_W-1:0] orow_q;
	logic [c2d_pkg::POS_W-1:0] ocol_q;

	// setup products and walk state
	logic [RC_W-1:0]           rc_q;
	logic [MP_W-1:0]           row0_q;
	logic [CK_W-1:0]           ck_q;
	logic [CKK_W-1:0]          ckk_q;
	logic [MP_W-1:0]           chan_base_q;
	logic [MP_W-1:0]           row_base_q;
	logic [MP_W-1:0]           ptr_q;
	logic [WP_W-1:0]           wa_q;
	logic [c2d_pkg::KER_W-1:0] j_q;
	logic [c2d_pkg::KER_W-1:0] i_q;
	logic [c2d_pkg::ICH_W-1:0] c_q;
	logic                      j_last, i_last, c_last;

	// stores
	logic signed [DW-1:0]      bias_q [MAX_OUT_CHANNELS];
	logic [OX_W-1:0]           och_in_x, och_q_x;
	logic                      map_we, wgt_we, bias_we;
	logic [DW-1:0]             map_rd, wgt_rd;
	logic signed [DW-1:0]      bias_rd;

	// multiply-accumulate pipeline
	logic                      issue_s1;
	logic                      wok_s1;
	logic                      val_s2;
	logic signed [c2d_pkg::PROD_W-1:0] prod_s2;
	logic signed [c2d_pkg::ACC_W-1:0]  acc_q;

	// position check
	logic [c2d_pkg::DIM_W:0]   row_end, col_end;
	logic                      bad_row, bad_col, bad_och;

	// result shaping
	logic signed [Q_W-1:0]     q;
	logic [Q_W-DW:0]           q_top;
	logic                      q_ovf;
	logic signed [DW-1:0]      q_sat;
	logic signed [DW-1:0]      conv_value_q;
	logic                      saturated_q;
	logic                      bad_position_q;

	assign op_e = c2d_pkg::op_t'(op);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= c2d_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (c2d_pkg::reg_idx_t'(cfg_index))
				c2d_pkg::REG_IN_ROWS:      cfg_q.in_rows      <= cfg_wdata;
				c2d_pkg::REG_IN_COLS:      cfg_q.in_cols      <= cfg_wdata;
				c2d_pkg::REG_IN_CHANNELS:  cfg_q.in_channels  <= cfg_wdata[c2d_pkg::ICH_W-1:0];
				c2d_pkg::REG_KERNEL_ROWS:  cfg_q.kernel_rows  <= cfg_wdata[c2d_pkg::KER_W-1:0];
				c2d_pkg::REG_KERNEL_COLS:  cfg_q.kernel_cols  <= cfg_wdata[c2d_pkg::KER_W-1:0];
				c2d_pkg::REG_OUT_CHANNELS: cfg_q.out_channels <= cfg_wdata[c2d_pkg::OCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// store writes: map wraps, out-of-range weights and biases are dropped
	assign och_in_x = OX_W'(out_channel);
	assign och_q_x  = OX_W'(och_q);
	assign map_we   = cmd.take && op_e == c2d_pkg::OP_MAP;
	assign wgt_we   = cmd.take && op_e == c2d_pkg::OP_WEIGHT &&
	                  (WP_W'(address) < WP_W'(WEIGHT_DEPTH));
	assign bias_we  = cmd.take && op_e == c2d_pkg::OP_BIAS &&
	                  (OC_W'(out_channel) < OC_W'(MAX_OUT_CHANNELS));

	always_ff @(posedge clk) begin
		if (bias_we) begin
			bias_q[och_in_x[BI_W-1:0]] <= value;
		end
	end

	assign bias_rd = bias_q[och_q_x[BI_W-1:0]];

	c2d_ram #(
		.WIDTH(DW),
		.DEPTH(MAP_DEPTH)
	) u_map_ram (
		.clk  (clk),
		.we   (map_we),
		.waddr(M_AW'(MP_W'(address))),
		.wdata(value),
		.raddr(ptr_q[M_AW-1:0]),
		.rdata(map_rd)
	);

	c2d_ram #(
		.WIDTH(DW),
		.DEPTH(WEIGHT_DEPTH)
	) u_wgt_ram (
		.clk  (clk),
		.we   (wgt_we),
		.waddr(W_AW'(WP_W'(address))),
		.wdata(value),
		.raddr(wa_q[W_AW-1:0]),
		.rdata(wgt_rd)
	);

	// capture the requested position
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			och_q  <= out_channel;
			orow_q <= out_row;
			ocol_q <= out_col;
		end
	end

	// position and loop status
	assign row_end = (c2d_pkg::DIM_W+1)'(orow_q) + (c2d_pkg::DIM_W+1)'(cfg_q.kernel_rows);
	assign col_end = (c2d_pkg::DIM_W+1)'(ocol_q) + (c2d_pkg::DIM_W+1)'(cfg_q.kernel_cols);
	assign bad_row = row_end > (c2d_pkg::DIM_W+1)'(cfg_q.in_rows);
	assign bad_col = col_end > (c2d_pkg::DIM_W+1)'(cfg_q.in_cols);
	assign bad_och = (c2d_pkg::OCNT_W'(och_q) >= cfg_q.out_channels) ||
	                 (OC_W'(och_q) >= OC_W'(MAX_OUT_CHANNELS));

	assign j_last = (j_q == cfg_q.kernel_cols - c2d_pkg::KER_W'(1));
	assign i_last = (i_q == cfg_q.kernel_rows - c2d_pkg::KER_W'(1));
	assign c_last = (c_q == cfg_q.in_channels - c2d_pkg::ICH_W'(1));

	assign sts.bad   = bad_row || bad_col || bad_och;
	assign sts.empty = (cfg_q.in_channels == '0) || (cfg_q.kernel_rows == '0) ||
	                   (cfg_q.kernel_cols == '0);
	assign sts.last  = j_last && i_last && c_last;
	assign sts.busy  = issue_s1 || val_s2;

	// setup products, one multiply per register
	always_ff @(posedge clk) begin
		if (cmd.setup1) begin
			rc_q   <= RC_W'(cfg_q.in_rows) * RC_W'(cfg_q.in_cols);
			row0_q <= MP_W'(orow_q) * MP_W'(cfg_q.in_cols) + MP_W'(ocol_q);
			ck_q   <= CK_W'(cfg_q.in_channels) * CK_W'(cfg_q.kernel_rows);
		end
		if (cmd.setup2) begin
			ckk_q <= CKK_W'(ck_q) * CKK_W'(cfg_q.kernel_cols);
		end
	end

	// address walk: column, then kernel row, then input channel
	always_ff @(posedge clk) begin
		if (cmd.setup2) begin
			chan_base_q <= row0_q;
			row_base_q  <= row0_q;
			ptr_q       <= row0_q;
			j_q         <= '0;
			i_q         <= '0;
			c_q         <= '0;
		end else if (cmd.setup3) begin
			wa_q <= WP_W'(och_q) * WP_W'(ckk_q);
		end else if (cmd.issue) begin
			wa_q <= wa_q + WP_W'(1);
			if (!j_last) begin
				j_q   <= j_q + c2d_pkg::KER_W'(1);
				ptr_q <= ptr_q + MP_W'(1);
			end else if (!i_last) begin
				j_q        <= '0;
				i_q        <= i_q + c2d_pkg::KER_W'(1);
				row_base_q <= row_base_q + MP_W'(cfg_q.in_cols);
				ptr_q      <= row_base_q + MP_W'(cfg_q.in_cols);
			end else begin
				j_q         <= '0;
				i_q         <= '0;
				c_q         <= c_q + c2d_pkg::ICH_W'(1);
				chan_base_q <= chan_base_q + MP_W'(rc_q);
				row_base_q  <= chan_base_q + MP_W'(rc_q);
				ptr_q       <= chan_base_q + MP_W'(rc_q);
			end
		end
	end

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			val_s2   <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
			val_s2   <= issue_s1;
		end
	end

	// weight beyond the store reads as zero
	always_ff @(posedge clk) begin
		wok_s1 <= wa_q < WP_W'(WEIGHT_DEPTH);
	end

	// multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= signed'(map_rd) * (wok_s1 ? signed'(wgt_rd) : DW'(signed'(0)));
	end

	// accumulate, preloaded with the bias in accumulator scale
	always_ff @(posedge clk) begin
		if (cmd.setup2) begin
			acc_q <= c2d_pkg::ACC_W'(bias_rd) <<< c2d_pkg::FRAC_SHIFT;
		end else if (val_s2) begin
			acc_q <= acc_q + c2d_pkg::ACC_W'(prod_s2);
		end
	end

	// drop fraction bits (floor) and clip to the data width
	assign q     = signed'(acc_q[c2d_pkg::ACC_W-1:c2d_pkg::FRAC_SHIFT]);
	assign q_top = q[Q_W-1:DW-1];
	assign q_ovf = !(&q_top) && (|q_top);
	assign q_sat = q[Q_W-1] ? signed'({1'b1, {(DW-1){1'b0}}})
	                        : signed'({1'b0, {(DW-1){1'b1}}});

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (sts.bad) begin
				conv_value_q   <= '0;
				saturated_q    <= 1'b0;
				bad_position_q <= 1'b1;
			end else begin
				conv_value_q   <= q_ovf ? q_sat : q[DW-1:0];
				saturated_q    <= q_ovf;
				bad_position_q <= 1'b0;
			end
		end
	end

	assign conv_value   = conv_value_q;
	assign saturated    = saturated_q;
	assign bad_position = bad_position_q;

endmodule

### rtl/conv2d_valid_multichannel_top.sv
// ----------------------------------------------------------------------------
// conv2d_valid_multichannel_top: multichannel valid convolution, stride 1
// Stores an input feature map, kernel weights and biases; a compute request
// returns one Q7.8 output element with saturation and position flags.
//
//   channel  handshake            payload
//   config   cfg_we               cfg_index, cfg_wdata
//   input    in_valid / in_ready  op, address, value, out_channel, out_row,
//                                 out_col
//   output   out_valid / out_ready conv_value, saturated, bad_position
//
// Write items are taken one per cycle while no compute item is in progress.
// A compute item runs the setup states, then a walk of N = in_channels *
// kernel_rows * kernel_cols steps on the single multiply-accumulate unit fed
// by the map and weight RAM ports, the pipeline drain and the result load.
// A position outside the output skips from the first setup to the load.
// Reset restores the register defaults; store contents are undefined until
// written. A result waiting on out_ready holds only the next compute item.
// ----------------------------------------------------------------------------
module conv2d_valid_multichannel_top #(
	parameter int unsigned MAP_DEPTH        = c2d_pkg::MAP_DEPTH_DEF,
	parameter int unsigned WEIGHT_DEPTH     = c2d_pkg::WEIGHT_DEPTH_DEF,
	parameter int unsigned MAX_OUT_CHANNELS = c2d_pkg::MAX_OUT_CHANNELS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [c2d_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [c2d_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [c2d_pkg::OP_W-1:0]              op,
	input  logic [c2d_pkg::ADDR_W-1:0]            address,
	input  logic signed [c2d_pkg::DATA_W-1:0]     value,
	input  logic [c2d_pkg::OCH_W-1:0]             out_channel,
	input  logic [c2d_pkg::POS_W-1:0]             out_row,
	input  logic [c2d_pkg::POS_W-1:0]             out_col,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [c2d_pkg::DATA_W-1:0]     conv_value,
	output logic                                  saturated,
	output logic                                  bad_position
);

	c2d_pkg::cmd_t cmd;
	c2d_pkg::sts_t sts;

	c2d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	c2d_dp #(
		.MAP_DEPTH       (MAP_DEPTH),
		.WEIGHT_DEPTH    (WEIGHT_DEPTH),
		.MAX_OUT_CHANNELS(MAX_OUT_CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.op          (op),
		.address     (address),
		.value       (value),
		.out_channel (out_channel),
		.out_row     (out_row),
		.out_col     (out_col),
		.cmd         (cmd),
		.sts         (sts),
		.conv_value  (conv_value),
		.saturated   (saturated),
		.bad_position(bad_position)
	);

endmodule

### tb/conv2d_valid_multichannel_top_test.sv
// ----------------------------------------------------------------------------
// conv2d_valid_multichannel_top_test: self-checking bench for the conv engine
// Loads map words, weights and biases and requests output elements through
// the valid/ready channels. A scoreboard class mirrors the stores and the
// registers, predicts every compute result in order and compares each output
// transfer field by field. Runs a directed opening, then random traffic over
// several register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module conv2d_valid_multichannel_top_test;
	import c2d_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam logic signed [ACC_W-1:0] Q_MAX = 32767;
	localparam logic signed [ACC_W-1:0] Q_MIN = -32768;

	typedef struct packed {
		op_t                op;
		logic [ADDR_W-1:0]  address;
		logic [DATA_W-1:0]  value;
		logic [OCH_W-1:0]   out_channel;
		logic [POS_W-1:0]   out_row;
		logic [POS_W-1:0]   out_col;
	} conv_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] conv_value;
		logic                     saturated;
		logic                     bad_position;
	} conv_result_t;

	// Mirror of the engine: stores, registers and the results still owed
	class conv_scoreboard;
		logic [DIM_W-1:0]  rows, cols;
		logic [ICH_W-1:0]  chans;
		logic [KER_W-1:0]  krows, kcols;
		logic [OCNT_W-1:0] kernels;
		logic [DATA_W-1:0] map_words [MAP_DEPTH_DEF];
		logic [DATA_W-1:0] weights [WEIGHT_DEPTH_DEF];
		logic [DATA_W-1:0] biases [MAX_OUT_CHANNELS_DEF];
		conv_result_t      results_due [$];
		int                errors;

		function new();
			rows = CFG_RESET.in_rows;
			cols = CFG_RESET.in_cols;
			chans = CFG_RESET.in_channels;
			krows = CFG_RESET.kernel_rows;
			kcols = CFG_RESET.kernel_cols;
			kernels = CFG_RESET.out_channels;
			errors = 0;
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_IN_ROWS: rows = data[DIM_W-1:0];
				REG_IN_COLS: cols = data[DIM_W-1:0];
				REG_IN_CHANNELS: chans = data[ICH_W-1:0];
				REG_KERNEL_ROWS: krows = data[KER_W-1:0];
				REG_KERNEL_COLS: kcols = data[KER_W-1:0];
				REG_OUT_CHANNELS: kernels = data[OCNT_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned out_rows();
			int unsigned r, k;
			r = rows;
			k = krows;
			return (k <= r) ? r - k + 1 : 0;
		endfunction

		function int unsigned out_cols();
			int unsigned r, k;
			r = cols;
			k = kcols;
			return (k <= r) ? r - k + 1 : 0;
		endfunction

		function bit off_output(int unsigned och, int unsigned row, int unsigned col);
			return och >= kernels || och >= MAX_OUT_CHANNELS_DEF ||
				row >= out_rows() || col >= out_cols();
		endfunction

		function int unsigned map_index(int unsigned c, int unsigned i, int unsigned j,
				int unsigned row, int unsigned col);
			return (c * rows * cols + (row + i) * cols + col + j) % MAP_DEPTH_DEF;
		endfunction

		function int unsigned weight_index(int unsigned o, int unsigned c, int unsigned i,
				int unsigned j);
			return ((o * chans + c) * krows + i) * kcols + j;
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		// Bias plus the multiply-accumulate over depth and kernel window
		function conv_result_t convolve_element(conv_item_t it);
			conv_result_t r;
			logic signed [ACC_W-1:0] acc;
			logic signed [ACC_W-1:0] scaled;
			logic signed [PROD_W-1:0] prod;
			logic signed [DATA_W-1:0] pixel, coef;
			int unsigned wi;
			r = '0;
			if (off_output(it.out_channel, it.out_row, it.out_col)) begin
				r.bad_position = 1'b1;
				return r;
			end
			coef = biases[it.out_channel];
			acc = coef;
			acc = acc <<< FRAC_SHIFT;
			for (int unsigned c = 0; c < chans; c++)
				for (int unsigned i = 0; i < krows; i++)
					for (int unsigned j = 0; j < kcols; j++) begin
						pixel = map_words[map_index(c, i, j, it.out_row, it.out_col)];
						wi = weight_index(it.out_channel, c, i, j);
						coef = (wi < WEIGHT_DEPTH_DEF) ? weights[wi] : '0;
						prod = pixel * coef;
						acc = acc + prod;
					end
			scaled = acc >>> FRAC_SHIFT;
			if (scaled > Q_MAX) begin
				r.conv_value = Q_MAX[DATA_W-1:0];
				r.saturated = 1'b1;
			end else if (scaled < Q_MIN) begin
				r.conv_value = Q_MIN[DATA_W-1:0];
				r.saturated = 1'b1;
			end else begin
				r.conv_value = scaled[DATA_W-1:0];
			end
			return r;
		endfunction

		// Apply an accepted input transfer to the mirror
		function void record_transfer(conv_item_t it);
			case (it.op)
				OP_MAP: map_words[it.address % MAP_DEPTH_DEF] = it.value;
				OP_WEIGHT: if (it.address < WEIGHT_DEPTH_DEF) weights[it.address] = it.value;
				OP_BIAS: biases[it.out_channel] = it.value;
				OP_COMPUTE: results_due.push_back(convolve_element(it));
				default: ;
			endcase
		endfunction

		// Compare an output transfer with the oldest result owed
		task check_result(conv_result_t got);
			conv_result_t due;
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("result %0d with none due", got.conv_value));
				return;
			end
			due = results_due.pop_front();
			if (got.conv_value !== due.conv_value)
				report_mismatch($sformatf("conv_value %0d, want %0d",
					got.conv_value, due.conv_value));
			if (got.saturated !== due.saturated)
				report_mismatch($sformatf("saturated %b, want %b", got.saturated, due.saturated));
			if (got.bad_position !== due.bad_position)
				report_mismatch($sformatf("bad_position %b, want %b",
					got.bad_position, due.bad_position));
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [OP_W-1:0]          op = '0;
	logic [ADDR_W-1:0]        address = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic [OCH_W-1:0]         out_channel = '0;
	logic [POS_W-1:0]         out_row = '0;
	logic [POS_W-1:0]         out_col = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] conv_value;
	logic                     saturated;
	logic                     bad_position;

	conv_scoreboard sb;
	int unsigned idle_pct = 36;
	int unsigned stall_pct = 36;
	int unsigned sent_count = 0;
	bit fill_fixed = 1'b0;
	logic [DATA_W-1:0] fill_word = '0;

	// entries already loaded, so computes never touch an empty one
	bit map_seen [MAP_DEPTH_DEF];
	bit weight_seen [WEIGHT_DEPTH_DEF];
	bit bias_seen [MAX_OUT_CHANNELS_DEF];

	conv2d_valid_multichannel_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.address      (address),
		.value        (value),
		.out_channel  (out_channel),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.conv_value   (conv_value),
		.saturated    (saturated),
		.bad_position (bad_position)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Track input transfers
	always @(posedge clk) begin
		conv_item_t seen;
		if (arst_n && in_valid && in_ready) begin
			seen.op = op_t'(op);
			seen.address = address;
			seen.value = value;
			seen.out_channel = out_channel;
			seen.out_row = out_row;
			seen.out_col = out_col;
			sb.record_transfer(seen);
		end
	end

	// Check output transfers
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{conv_value, saturated, bad_position});
	end

	function automatic logic [DATA_W-1:0] pick_value();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 35)
			return DATA_W'($urandom_range(1023)) - DATA_W'(512);
		if (pick < 50)
			return DATA_W'($urandom_range(16383)) - DATA_W'(8192);
		if (pick < 65) begin
			case ($urandom_range(4))
				0: return 16'h7FFF;
				1: return 16'h8000;
				2: return 16'hFFFF;
				3: return 16'h0001;
				default: return 16'h0000;
			endcase
		end
		return DATA_W'($urandom);
	endfunction

	// Present one item and hold it until the transfer
	task automatic send_item(conv_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op;
		address <= it.address;
		value <= it.value;
		out_channel <= it.out_channel;
		out_row <= it.out_row;
		out_col <= it.out_col;
		case (it.op)
			OP_MAP: map_seen[it.address % MAP_DEPTH_DEF] = 1'b1;
			OP_WEIGHT: if (it.address < WEIGHT_DEPTH_DEF) weight_seen[it.address] = 1'b1;
			OP_BIAS: bias_seen[it.out_channel] = 1'b1;
			default: ;
		endcase
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_count++;
	endtask

	task automatic send_fill(op_t kind, int unsigned addr, logic [OCH_W-1:0] och);
		conv_item_t it;
		it.op = kind;
		it.address = ADDR_W'(addr);
		it.value = fill_fixed ? fill_word : pick_value();
		it.out_channel = och;
		it.out_row = POS_W'($urandom);
		it.out_col = POS_W'($urandom);
		send_item(it);
	endtask

	// Load every entry a compute will read that is still empty
	task automatic make_ready(conv_item_t it);
		int unsigned mi, wi;
		if (sb.off_output(it.out_channel, it.out_row, it.out_col))
			return;
		if (!bias_seen[it.out_channel])
			send_fill(OP_BIAS, $urandom, it.out_channel);
		for (int unsigned c = 0; c < sb.chans; c++)
			for (int unsigned i = 0; i < sb.krows; i++)
				for (int unsigned j = 0; j < sb.kcols; j++) begin
					mi = sb.map_index(c, i, j, it.out_row, it.out_col);
					if (!map_seen[mi])
						send_fill(OP_MAP, mi, OCH_W'($urandom));
					wi = sb.weight_index(it.out_channel, c, i, j);
					if (wi < WEIGHT_DEPTH_DEF && !weight_seen[wi])
						send_fill(OP_WEIGHT, wi, OCH_W'($urandom));
				end
	endtask

	task automatic deliver(conv_item_t it);
		if (it.op == OP_COMPUTE)
			make_ready(it);
		send_item(it);
	endtask

	task automatic issue(op_t kind, int unsigned addr, logic [DATA_W-1:0] data,
			int unsigned och, int unsigned row, int unsigned col);
		deliver('{kind, ADDR_W'(addr), data, OCH_W'(och), POS_W'(row), POS_W'(col)});
	endtask

	function automatic conv_item_t random_item();
		conv_item_t it;
		int unsigned pick, span, orows, ocols, och_lim;
		it.op = OP_MAP;
		it.address = ADDR_W'($urandom);
		it.value = pick_value();
		it.out_channel = OCH_W'($urandom);
		it.out_row = POS_W'($urandom);
		it.out_col = POS_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 30) begin
			// mostly inside the active map, sometimes anywhere
			span = sb.chans * sb.rows * sb.cols;
			if (span != 0 && $urandom_range(4) != 0)
				it.address = ADDR_W'($urandom_range(span - 1) % MAP_DEPTH_DEF);
		end else if (pick < 45) begin
			it.op = OP_WEIGHT;
			span = sb.kernels * sb.chans * sb.krows * sb.kcols;
			if (span > WEIGHT_DEPTH_DEF)
				span = WEIGHT_DEPTH_DEF;
			if (span != 0 && $urandom_range(6) != 0)
				it.address = ADDR_W'($urandom_range(span - 1));
		end else if (pick < 52) begin
			it.op = OP_BIAS;
		end else begin
			it.op = OP_COMPUTE;
			orows = (sb.out_rows() > 32) ? 32 : sb.out_rows();
			ocols = (sb.out_cols() > 32) ? 32 : sb.out_cols();
			och_lim = (sb.kernels > MAX_OUT_CHANNELS_DEF) ? MAX_OUT_CHANNELS_DEF : sb.kernels;
			if (orows != 0 && ocols != 0 && och_lim != 0 && $urandom_range(4) != 0) begin
				it.out_channel = OCH_W'($urandom_range(och_lim - 1));
				it.out_row = POS_W'($urandom_range(orows - 1));
				it.out_col = POS_W'($urandom_range(ocols - 1));
			end
		end
		return it;
	endfunction

	// Send random items until the phase budget, loads included, is spent
	task automatic run_random(int unsigned count);
		conv_item_t it;
		int unsigned start;
		start = sent_count;
		while (sent_count - start < count) begin
			it = random_item();
			deliver(it);
		end
	endtask

	// Drop valid and let every owed result come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int unsigned data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(data);
		@(posedge clk);
		sb.set_reg(idx, CFG_DATA_W'(data));
	endtask

	task automatic run_phase(int unsigned r, int unsigned c, int unsigned ch, int unsigned kr,
			int unsigned kc, int unsigned oc, int unsigned count);
		wait_drained();
		write_reg(REG_IN_ROWS, r);
		write_reg(REG_IN_COLS, c);
		write_reg(REG_IN_CHANNELS, ch);
		write_reg(REG_KERNEL_ROWS, kr);
		write_reg(REG_KERNEL_COLS, kc);
		write_reg(REG_OUT_CHANNELS, oc);
		cfg_we <= 1'b0;
		run_random(count);
	endtask

	// Opening sequence on the reset settings: 28x28 map, one channel, 3x3, two kernels
	task automatic directed_part();
		// full-scale positive weights and map: clip high
		fill_fixed = 1'b1;
		fill_word = 16'h7FFF;
		issue(OP_BIAS, $urandom, 16'h7FFF, 0, $urandom, $urandom);
		issue(OP_COMPUTE, $urandom, DATA_W'($urandom), 0, 0, 0);
		// most negative weights on the second kernel: clip low
		fill_word = 16'h8000;
		issue(OP_BIAS, $urandom, 16'h8000, 1, $urandom, $urandom);
		issue(OP_COMPUTE, $urandom, DATA_W'($urandom), 1, 0, 0);
		// last valid corner, most negative times most negative
		issue(OP_COMPUTE, $urandom, DATA_W'($urandom), 1, 25, 25);
		fill_fixed = 1'b0;
		// positions outside the output
		issue(OP_COMPUTE, $urandom, DATA_W'($urandom), 2, 3, 3);
		issue(OP_COMPUTE, $urandom, DATA_W'($urandom), 3, 0, 0);
		issue(OP_COMPUTE, $urandom, DATA_W'($urandom), 0, 26, 0);
		issue(OP_COMPUTE, $urandom, DATA_W'($urandom), 0, 0, 26);
		issue(OP_COMPUTE, $urandom, DATA_W'($urandom), 1, 31, 31);
		// store edges, and weight writes beyond the store
		issue(OP_BIAS, $urandom, pick_value(), 3, $urandom, $urandom);
		issue(OP_MAP, 2047, 16'h8000, 0, 31, 31);
		issue(OP_MAP, 1024, 16'h5555, 0, 0, 0);
		issue(OP_WEIGHT, 2047, 16'h1234, 3, 31, 31);
		issue(OP_WEIGHT, 256, 16'hFFFF, 0, 0, 0);
		issue(OP_WEIGHT, 255, 16'hAAAA, 0, 0, 0);
		issue(OP_MAP, 0, 16'h0001, 0, 0, 0);
		issue(OP_WEIGHT, 0, 16'hFFFF, 0, 0, 0);
		issue(OP_COMPUTE, $urandom, DATA_W'($urandom), 0, 0, 0);
		issue(OP_COMPUTE, $urandom, DATA_W'($urandom), 0, 12, 7);
		issue(OP_COMPUTE, $urandom, DATA_W'($urandom), 1, 5, 20);
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_part();
		run_random(300);
		run_phase(32, 32, 2, 5, 5, 4, 400);
		run_phase(1, 1, 1, 1, 1, 1, 120);
		// back-to-back stretch on both channels
		idle_pct = 0;
		stall_pct = 0;
		run_phase(8, 12, 2, 3, 2, 3, 260);
		wait_drained();
		idle_pct = 36;
		stall_pct = 36;
		run_phase(5, 7, 1, 5, 1, 4, 150);
		// no input channels: bias only
		run_phase(6, 6, 0, 2, 2, 2, 100);
		// empty kernel over a map one larger
		run_phase(4, 5, 1, 0, 0, 2, 100);
		// kernel larger than the map: every position is outside
		run_phase(3, 3, 1, 5, 5, 2, 80);
		// registers beyond their normal range, map reads wrap
		run_phase(40, 50, 3, 6, 7, 7, 150);
		run_phase(16, 20, 2, 4, 3, 3, 215);
		wait_drained();
		if (sb.errors == 0)
			$display("PASS conv2d_valid_multichannel_top");
		else
			$display("FAIL conv2d_valid_multichannel_top");
		$finish;
	end

	// Hard stop for a hung run
	initial begin
		#24_000_000;
		$display("FAIL conv2d_valid_multichannel_top");
		$finish;
	end

endmodule

### files.f
rtl/c2d_pkg.sv
rtl/c2d_ram.sv
rtl/c2d_ctrl.sv
rtl/c2d_dp.sv
rtl/conv2d_valid_multichannel_top.sv
tb/conv2d_valid_multichannel_top_test.sv
